/* sv/retargetable_weight_fade_ramp_core_macros.svh */
// ----------------------------------------------------------------------------
// retargetable weight fade ramp - assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef RETARGETABLE_WEIGHT_FADE_RAMP_CORE_MACROS_SVH
`define RETARGETABLE_WEIGHT_FADE_RAMP_CORE_MACROS_SVH

// same-cycle implication
`define RWFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RWFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rwfr_pkg.sv */
// ----------------------------------------------------------------------------
// rwfr_pkg
// shared types and constants of the retargetable weight fade ramp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwfr_pkg;

    // fixed field widths
    localparam int FADE_W = 24;
    localparam int TICK_W = 20;

    // fade length limits in microseconds
    localparam logic [FADE_W-1:0] FADE_DEFAULT_US = 24'd200000;
    localparam logic [FADE_W-1:0] FADE_LIMIT_US   = 24'd10000000;

    // register index of default_fade_us
    localparam logic CFG_IDX_DEFAULT_FADE = 1'b0;

    // pose action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_PASS = 2'd1;
    localparam logic [1:0] ACT_REST = 2'd2;

    // request to the shared multiply / divide unit
    typedef struct packed {
        logic start;
        logic divide;
    } t_md_req;

    // status of the shared multiply / divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

endpackage

/* sv/rwfr_muldiv.sv */
// ----------------------------------------------------------------------------
// rwfr_muldiv
// shared multiplier with an optional restoring divide of the product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwfr_muldiv
    import rwfr_pkg::*;
#(
    parameter int QW = 16,
    parameter int TW = 24,
    parameter int MB = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_md_req           i_req,
    input  logic [QW-1:0]     i_a,
    input  logic [MB-1:0]     i_b,
    input  logic [TW-1:0]     i_len,
    output t_md_stat          o_stat,
    output logic [QW+MB-1:0]  o_prod,
    output logic [QW-1:0]     o_quot
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;
    localparam logic [1:0] P_DONE = 2'd3;

    logic [1:0]        r_phase, n_phase;
    logic              r_div;
    logic [CW-1:0]     r_cnt;
    logic [QW+MB-1:0]  r_prod;
    logic [TW-1:0]     r_rem;
    logic [QW-1:0]     r_q;
    logic [TW:0]       trial;
    logic              ge;

    // one restoring step: shift in next dividend bit, subtract when it fits
    assign trial = {r_rem, r_q[QW-1]};
    assign ge    = trial >= {1'b0, i_len};

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            P_IDLE: if (i_req.start) n_phase = P_MUL;
            P_MUL:  n_phase = r_div ? P_DIV : P_DONE;
            P_DIV:  if (r_cnt == CNT_LAST) n_phase = P_DONE;
            P_DONE: n_phase = P_IDLE;
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_phase == P_IDLE && i_req.start) begin
            r_prod <= i_a * i_b;
            r_div  <= i_req.divide;
        end
        if (r_phase == P_MUL) begin
            r_rem <= r_prod[QW+TW-1:QW];
            r_q   <= r_prod[QW-1:0];
            r_cnt <= '0;
        end
        if (r_phase == P_DIV) begin
            r_rem <= ge ? TW'(trial - {1'b0, i_len}) : trial[TW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_stat.busy = r_phase != P_IDLE;
    assign o_stat.done = r_phase == P_DONE;
    assign o_prod      = r_prod;
    assign o_quot      = r_q;

endmodule

/* sv/retargetable_weight_fade_ramp_core.sv */
// ----------------------------------------------------------------------------
// retargetable_weight_fade_ramp_core
// linear weight fade that restarts from its present level on a new target
// ----------------------------------------------------------------------------
// one tick runs from accept through an optional retarget divide during a fade,
// an optional ramp point divide and an optional pose scaling on the shared unit
// a result waits while the output stalls, and no new request is taken until
// the sequencer is back in idle
// a tick with pose_connected low gives no result
// synchronous active-low reset clears all fade state, default fade 200 ms
`timescale 1ns / 1ps

`include "retargetable_weight_fade_ramp_core_macros.svh"

module retargetable_weight_fade_ramp_core
    import rwfr_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 15,
    parameter int TIME_BITS        = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_pose_connected,
    input  logic                        i_target_given,
    input  logic [WEIGHT_FRAC_BITS:0]   i_target_weight,
    input  logic                        i_fade_given,
    input  logic [FADE_W-1:0]           i_fade_override_us,
    input  logic [TICK_W-1:0]           i_tick_us,
    input  logic                        i_pose_present,
    input  logic                        i_pose_command_valid,
    input  logic [WEIGHT_FRAC_BITS:0]   i_pose_weight,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [WEIGHT_FRAC_BITS:0]   o_current_weight,
    output logic                        o_faded_out,
    output logic                        o_faded_in,
    output logic [1:0]                  o_pose_action,
    output logic [WEIGHT_FRAC_BITS:0]   o_output_pose_weight
);

    localparam int QW = WEIGHT_FRAC_BITS + 1;
    localparam int TW = TIME_BITS;
    localparam int MB = (TW > QW) ? TW : QW;
    localparam logic [QW-1:0] W_ONE  = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam logic [32:0]   T_MAX  = (33'd1 << TIME_BITS) - 33'd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_CAPW  = 4'd2;
    localparam logic [3:0] S_ADV   = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_RAMPW = 4'd5;
    localparam logic [3:0] S_POSE  = 4'd6;
    localparam logic [3:0] S_POSEW = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]         r_state;
    logic [FADE_W-1:0]  r_default;
    logic [QW-1:0]      r_start, r_end;
    logic [TW-1:0]      r_elapsed, r_len;

    // latched request
    logic               r_tg, r_fg, r_pres, r_cmdv;
    logic [QW-1:0]      r_tw, r_pw_in;
    logic [FADE_W-1:0]  r_fo;
    logic [TICK_W-1:0]  r_tick;

    // per-tick working values
    logic               r_running;
    logic [QW-1:0]      r_cur, r_pwo;
    logic               r_fout, r_fin;
    logic [1:0]         r_act;

    // output register
    logic               r_out_valid;
    logic [QW-1:0]      r_o_cur, r_o_pw;
    logic               r_o_fout, r_o_fin;
    logic [1:0]         r_o_act;

    logic               in_acc, cfg_wr, out_free;
    logic               running, change, dec;
    logic [QW-1:0]      target, diff, ramp_val, pw_sat;
    logic [FADE_W-1:0]  dflt, fade;
    logic [TW-1:0]      len_new, elapsed_new;
    logic [32:0]        el_sum;

    t_md_req            md_req;
    t_md_stat           md_stat;
    logic [QW-1:0]      md_a;
    logic [MB-1:0]      md_b;
    logic [QW+MB-1:0]   md_prod;
    logic [QW-1:0]      md_quot;

    // handshakes
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == CFG_IDX_DEFAULT_FADE) ? 32'(r_default) : 32'd0;

    // target, fade length and retarget decision
    assign running = r_elapsed < r_len;
    assign target  = !r_tg ? W_ONE : ((r_tw > W_ONE) ? W_ONE : r_tw);
    assign change  = r_end != target;
    assign dflt    = (r_default > FADE_LIMIT_US) ? FADE_LIMIT_US : r_default;
    assign fade    = r_fg ? r_fo : dflt;
    assign len_new = (33'(fade) > T_MAX) ? T_MAX[TW-1:0] : TW'(fade);

    // play time advance with saturation
    assign el_sum      = 33'(r_elapsed) + 33'(r_tick);
    assign elapsed_new = (el_sum > T_MAX) ? T_MAX[TW-1:0] : el_sum[TW-1:0];

    // ramp step direction and span
    assign dec      = r_end < r_start;
    assign diff     = dec ? (r_start - r_end) : (r_end - r_start);
    assign ramp_val = dec ? (r_start - md_quot) : (r_start + md_quot);
    assign pw_sat   = (r_pw_in > W_ONE) ? W_ONE : r_pw_in;

    // shared unit operands: ramp span times play time, or pose scaling
    always_comb begin
        md_req.start  = 1'b0;
        md_req.divide = 1'b1;
        md_a          = diff;
        md_b          = MB'(r_elapsed);
        unique case (r_state)
            S_EVAL: md_req.start = change && running;
            S_CMP:  md_req.start = r_elapsed < r_len;
            S_POSE: begin
                md_req.start  = (r_cur != '0) && r_pres && r_cmdv;
                md_req.divide = 1'b0;
                md_a          = pw_sat;
                md_b          = MB'(r_cur);
            end
            default: md_req.start = 1'b0;
        endcase
    end

    rwfr_muldiv #(
        .QW (QW),
        .TW (TW),
        .MB (MB)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_len   (r_len),
        .o_stat  (md_stat),
        .o_prod  (md_prod),
        .o_quot  (md_quot)
    );

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tg    <= i_target_given;
            r_tw    <= i_target_weight;
            r_fg    <= i_fade_given;
            r_fo    <= i_fade_override_us;
            r_tick  <= i_tick_us;
            r_pres  <= i_pose_present;
            r_cmdv  <= i_pose_command_valid;
            r_pw_in <= i_pose_weight;
        end
    end

    // sequencer and fade state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_default <= FADE_DEFAULT_US;
            r_start   <= '0;
            r_end     <= '0;
            r_elapsed <= '0;
            r_len     <= '0;
        end else begin
            if (cfg_wr && paddr[2] == CFG_IDX_DEFAULT_FADE) begin
                r_default <= pwdata[FADE_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_pose_connected) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_running <= running;
                    if (!change) begin
                        r_state <= S_ADV;
                    end else if (running) begin
                        r_state <= S_CAPW;
                    end else begin
                        r_start   <= r_end;
                        r_end     <= target;
                        r_elapsed <= '0;
                        r_len     <= len_new;
                        r_state   <= S_ADV;
                    end
                end
                S_CAPW: begin
                    if (md_stat.done) begin
                        r_start   <= ramp_val;
                        r_end     <= target;
                        r_elapsed <= '0;
                        r_len     <= len_new;
                        r_state   <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_elapsed <= elapsed_new;
                    r_state   <= S_CMP;
                end
                S_CMP: begin
                    if (r_elapsed >= r_len) begin
                        r_cur   <= r_end;
                        r_fout  <= r_running && (r_end == '0);
                        r_fin   <= r_running && (r_end >= W_ONE);
                        r_state <= S_POSE;
                    end else begin
                        r_state <= S_RAMPW;
                    end
                end
                S_RAMPW: begin
                    if (md_stat.done) begin
                        r_cur   <= ramp_val;
                        r_fout  <= 1'b0;
                        r_fin   <= 1'b0;
                        r_state <= S_POSE;
                    end
                end
                S_POSE: begin
                    if (r_cur == '0) begin
                        r_act   <= ACT_NONE;
                        r_pwo   <= '0;
                        r_state <= S_OUT;
                    end else if (!r_pres) begin
                        r_act   <= ACT_REST;
                        r_pwo   <= r_cur;
                        r_state <= S_OUT;
                    end else if (r_cmdv) begin
                        r_act   <= ACT_PASS;
                        r_state <= S_POSEW;
                    end else begin
                        r_act   <= ACT_NONE;
                        r_pwo   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_POSEW: begin
                    if (md_stat.done) begin
                        r_pwo   <= md_prod[WEIGHT_FRAC_BITS+QW-1:WEIGHT_FRAC_BITS];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_cur  <= r_cur;
            r_o_fout <= r_fout;
            r_o_fin  <= r_fin;
            r_o_act  <= r_act;
            r_o_pw   <= r_pwo;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_current_weight     = r_o_cur;
    assign o_faded_out          = r_o_fout;
    assign o_faded_in           = r_o_fin;
    assign o_pose_action        = r_o_act;
    assign o_output_pose_weight = r_o_pw;

    // checks
    `RWFR_ASSERT_IMP(a_weight_range, o_out_valid, o_current_weight <= W_ONE,
        "current weight above one")
    `RWFR_ASSERT_IMP(a_pulse_excl, o_out_valid, !(o_faded_out && o_faded_in),
        "faded out and faded in together")
    `RWFR_ASSERT_IMP(a_none_zero, o_out_valid && o_pose_action == ACT_NONE,
        o_output_pose_weight == '0, "no pose action with nonzero pose weight")
    `RWFR_ASSERT_IMP(a_unit_idle, r_state == S_IDLE, !md_stat.busy,
        "shared unit busy while sequencer idle")
    `RWFR_ASSERT_NXT(a_ramp_in_span, r_state == S_RAMPW && md_stat.done,
        (r_cur >= r_start && r_cur <= r_end) || (r_cur <= r_start && r_cur >= r_end),
        "ramp point outside start and end")

endmodule

/* verif/retargetable_weight_fade_ramp_core_tb.sv */
// ----------------------------------------------------------------------------
// retargetable_weight_fade_ramp_core_tb
// self-checking bench for the retargetable weight fade ramp: a queue-fed
// driver offers tick requests, a clocked predictor tracks the fade state and
// the monitor compares every result field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module retargetable_weight_fade_ramp_core_tb;
    import rwfr_pkg::*;

    localparam int WFB       = 15;
    localparam int TIME_BITS = 24;
    localparam logic [WFB:0]           W_ONE = (WFB+1)'(1 << WFB);
    localparam logic [TIME_BITS-1:0]   T_MAX = '1;
    localparam logic [2:0] ADDR_DEFAULT_FADE = 3'(4 * int'(CFG_IDX_DEFAULT_FADE));
    localparam int PHASE_TICKS = 540;
    localparam int DRAIN_CYCLES = 60;

    // one tick request
    typedef struct packed {
        logic               conn;
        logic               tgt_given;
        logic [WFB:0]       tgt_w;
        logic               fade_given;
        logic [FADE_W-1:0]  fade_ovr;
        logic [TICK_W-1:0]  tick;
        logic               present;
        logic               cmd_valid;
        logic [WFB:0]       pose_w;
    } t_fade_tick;

    // one fade result
    typedef struct packed {
        logic [WFB:0]   cur_w;
        logic           fout;
        logic           fin;
        logic [1:0]     act;
        logic [WFB:0]   pose_w;
    } t_fade_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_fade_tick  drv_req     = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [WFB:0] o_current_weight;
    logic        o_faded_out;
    logic        o_faded_in;
    logic [1:0]  o_pose_action;
    logic [WFB:0] o_output_pose_weight;

    // predictor copy of the fade state and the register
    logic [WFB:0]         ramp_start   = '0;
    logic [WFB:0]         ramp_end     = '0;
    logic [TIME_BITS-1:0] play_us      = '0;
    logic [TIME_BITS-1:0] fade_len_us  = '0;
    logic [FADE_W-1:0]    dflt_fade_us = FADE_DEFAULT_US;
    logic [WFB:0]         next_tgt     = '0;

    t_fade_tick pending_ticks[$];
    t_fade_res  expected_results[$];

    int snd_idle_pct = 18;
    int rcv_idle_pct = 54;
    logic req_taken  = 1'b0;
    int hold_cnt     = 0;
    bit hold_done    = 1'b0;
    int errors       = 0;
    int ticks_sent   = 0;
    int results_seen = 0;
    int pulses_in    = 0;
    int pulses_out   = 0;
    int rest_poses   = 0;
    int cfg_writes   = 0;

    always #10 i_clk = ~i_clk;

    retargetable_weight_fade_ramp_core #(
        .WEIGHT_FRAC_BITS(WFB),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_pose_connected(drv_req.conn),
        .i_target_given(drv_req.tgt_given),
        .i_target_weight(drv_req.tgt_w),
        .i_fade_given(drv_req.fade_given),
        .i_fade_override_us(drv_req.fade_ovr),
        .i_tick_us(drv_req.tick),
        .i_pose_present(drv_req.present),
        .i_pose_command_valid(drv_req.cmd_valid),
        .i_pose_weight(drv_req.pose_w),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_current_weight(o_current_weight),
        .o_faded_out(o_faded_out),
        .o_faded_in(o_faded_in),
        .o_pose_action(o_pose_action),
        .o_output_pose_weight(o_output_pose_weight)
    );

    // weight saturation to one
    function automatic logic [WFB:0] clamp_weight(input logic [WFB:0] w);
        return (w > W_ONE) ? W_ONE : w;
    endfunction

    // linear point between a and b, step magnitude floored
    function automatic logic [WFB:0] lerp_weight(input logic [WFB:0] a, input logic [WFB:0] b,
                                                 input logic [TIME_BITS-1:0] pos,
                                                 input logic [TIME_BITS-1:0] len);
        longint unsigned la, lb, lp, ll, r;
        la = a;
        lb = b;
        lp = pos;
        ll = len;
        if (ll == 0)
            return b;
        if (lb >= la)
            r = la + ((lb - la) * lp) / ll;
        else
            r = la - ((la - lb) * lp) / ll;
        return r[WFB:0];
    endfunction

    // advance the fade state by one tick, returns 1 when a result is due
    function automatic bit predict_fade_step(input t_fade_tick t, output t_fade_res r);
        logic [WFB:0]         tgt;
        logic [FADE_W-1:0]    fade;
        logic [WFB:0]         cur;
        longint unsigned      sum, prod;
        bit                   running;
        r = '0;
        if (!t.conn)
            return 1'b0;
        running = play_us < fade_len_us;
        tgt = t.tgt_given ? clamp_weight(t.tgt_w) : W_ONE;

        // retarget from the present level
        if (ramp_end != tgt) begin
            ramp_start = running ? lerp_weight(ramp_start, ramp_end, play_us, fade_len_us)
                                 : ramp_end;
            ramp_end = tgt;
            play_us = '0;
            if (t.fade_given)
                fade = t.fade_ovr;
            else
                fade = (dflt_fade_us > FADE_LIMIT_US) ? FADE_LIMIT_US : dflt_fade_us;
            fade_len_us = fade;
        end

        // saturating play time
        sum = longint'(play_us) + longint'(t.tick);
        play_us = (sum > longint'(T_MAX)) ? T_MAX : sum[TIME_BITS-1:0];

        if (play_us >= fade_len_us) begin
            cur = ramp_end;
            r.fout = running && (cur == 0);
            r.fin = running && (cur >= W_ONE);
        end else begin
            cur = lerp_weight(ramp_start, ramp_end, play_us, fade_len_us);
        end

        // pose selection
        r.act = ACT_NONE;
        if (cur != 0) begin
            if (t.present) begin
                if (t.cmd_valid) begin
                    r.act = ACT_PASS;
                    prod = (longint'(clamp_weight(t.pose_w)) * longint'(cur)) >> WFB;
                    r.pose_w = prod[WFB:0];
                end
            end else begin
                r.act = ACT_REST;
                r.pose_w = cur;
            end
        end
        r.cur_w = cur;
        return 1'b1;
    endfunction

    // random tick, targets held for a while so fades run to completion
    function automatic t_fade_tick gen_random_tick();
        t_fade_tick t;
        int unsigned sel;
        t.conn = ($urandom_range(15) != 0);
        t.tgt_given = ($urandom_range(7) != 0);
        if ($urandom_range(99) < 30) begin
            sel = $urandom_range(99);
            if (sel < 25)
                next_tgt = '0;
            else if (sel < 50)
                next_tgt = W_ONE;
            else if (sel < 85)
                next_tgt = (WFB+1)'($urandom_range(32768));
            else
                next_tgt = (WFB+1)'($urandom);
        end
        t.tgt_w = t.tgt_given ? next_tgt : (WFB+1)'($urandom);
        t.fade_given = 1'($urandom_range(1));
        sel = $urandom_range(99);
        if (sel < 10)
            t.fade_ovr = '0;
        else if (sel < 80)
            t.fade_ovr = FADE_W'($urandom_range(2000, 1));
        else
            t.fade_ovr = FADE_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 5)
            t.tick = '0;
        else if (sel < 75)
            t.tick = TICK_W'($urandom_range(800, 1));
        else if (sel < 90)
            t.tick = TICK_W'($urandom);
        else
            t.tick = '1;
        t.present = ($urandom_range(3) != 0);
        t.cmd_valid = ($urandom_range(3) != 0);
        t.pose_w = ($urandom_range(4) != 0) ? (WFB+1)'($urandom_range(32768))
                                            : (WFB+1)'($urandom);
        return t;
    endfunction

    task automatic add_tick(input logic conn, input logic tg, input logic [WFB:0] tw,
                            input logic fg, input logic [FADE_W-1:0] fo,
                            input logic [TICK_W-1:0] tk, input logic pp, input logic cv,
                            input logic [WFB:0] pw);
        t_fade_tick t;
        t = '{conn, tg, tw, fg, fo, tk, pp, cv, pw};
        pending_ticks.push_back(t);
    endtask

    task automatic add_random_ticks(input int n);
        repeat (n) pending_ticks.push_back(gen_random_tick());
    endtask

    // hold stimulus until every request is in and every result is out
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write followed by a read back
    task automatic write_default_fade(input logic [FADE_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEFAULT_FADE;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        dflt_fade_us = value;
        cfg_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(value)) begin
            $error("default_fade_us read back expected %0d got %0d", value, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s expected %0d got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    // request driver, payload held while stalled
    always @(negedge i_clk) begin
        if (!i_in_valid || req_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                drv_req    <= pending_ticks.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt - 1;
        end else if (!hold_done && results_seen >= 120) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= 400;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // accepted requests feed the predictor, accepted results are checked
    always @(posedge i_clk) begin : monitor
        t_fade_res exp_r;
        req_taken <= i_in_valid && !o_in_stall;
        if (i_in_valid && !o_in_stall) begin
            ticks_sent++;
            if (predict_fade_step(drv_req, exp_r))
                expected_results.push_back(exp_r);
        end
        if (o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with no pending request, current_weight %0d", o_current_weight);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("current_weight", exp_r.cur_w, o_current_weight);
                check_field("faded_out", exp_r.fout, o_faded_out);
                check_field("faded_in", exp_r.fin, o_faded_in);
                check_field("pose_action", exp_r.act, o_pose_action);
                check_field("output_pose_weight", exp_r.pose_w, o_output_pose_weight);
                if (exp_r.fin) pulses_in++;
                if (exp_r.fout) pulses_out++;
                if (exp_r.act == ACT_REST) rest_poses++;
            end
        end
    end

    // run time limit
    initial begin
        #(64'd20_000_000);
        $display("Verification failed");
        $finish;
    end

    // stimulus sequence
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ramp up on the reset default fade, saturated weights, fade-in pulse
        add_tick(1, 0, 0, 0, 0, 50000, 1, 1, W_ONE);
        add_tick(1, 1, '1, 0, 0, 50000, 1, 1, '1);
        add_tick(1, 1, W_ONE, 0, 0, 100000, 1, 1, 16384);
        // unconnected pose gives nothing
        add_tick(0, 1, 0, 1, 5, 100, 1, 1, 100);
        // zero fade length, zero weight
        add_tick(1, 1, 0, 1, 0, 0, 1, 1, W_ONE);
        // longest fade, longest ticks until play time saturates, rest pose
        add_tick(1, 1, 16384, 1, '1, '1, 0, 0, 0);
        for (int k = 0; k < 16; k++)
            add_tick(1, 1, 16384, 0, 0, '1, k[0], k[1], (WFB+1)'($urandom));
        wait_drained();

        // default fade above the 10 s clamp, retarget mid-fade, fade-out pulse
        write_default_fade('1);
        add_tick(1, 1, 0, 0, 0, 1000000, 1, 1, W_ONE);
        add_tick(1, 1, 8000, 1, 100, 60, 1, 1, W_ONE);
        add_tick(1, 1, 0, 1, 100, 60, 1, 1, W_ONE);
        add_tick(1, 1, 0, 0, 0, 60, 1, 0, W_ONE);
        wait_drained();

        // random phases with different idling and default fades
        write_default_fade(24'd1500);
        add_random_ticks(PHASE_TICKS);
        wait_drained();

        snd_idle_pct = 54;
        rcv_idle_pct = 18;
        write_default_fade(FADE_LIMIT_US);
        add_random_ticks(PHASE_TICKS);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_default_fade('0);
        add_random_ticks(PHASE_TICKS);
        wait_drained();

        errors += expected_results.size();
        $display("%0d tick requests, %0d results checked, %0d rest poses", ticks_sent,
                 results_seen, rest_poses);
        $display("%0d fade-in and %0d fade-out pulses over %0d default fade settings",
                 pulses_in, pulses_out, cfg_writes + 1);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/rwfr_pkg.sv
sv/rwfr_muldiv.sv
sv/retargetable_weight_fade_ramp_core.sv
verif/retargetable_weight_fade_ramp_core_tb.sv
